// ----- rtl/cstm_pkg.sv -----
// Shared types, codes and lookup functions of the C source token minifier.
`default_nettype none

package cstm_pkg;

    // Lexer state codes
    localparam logic [3:0] ST_BASE       = 4'd0;
    localparam logic [3:0] ST_CHR        = 4'd1;
    localparam logic [3:0] ST_CHR_ESC    = 4'd2;
    localparam logic [3:0] ST_CHR_WAIT   = 4'd3;
    localparam logic [3:0] ST_SLASH_SEEN = 4'd4;
    localparam logic [3:0] ST_LINE_CMT   = 4'd5;
    localparam logic [3:0] ST_BLK_CMT    = 4'd6;
    localparam logic [3:0] ST_BLK_END    = 4'd7;
    localparam logic [3:0] ST_NUM        = 4'd8;
    localparam logic [3:0] ST_SYM        = 4'd9;
    localparam logic [3:0] ST_NAME       = 4'd10;
    localparam logic [3:0] ST_STR        = 4'd11;
    localparam logic [3:0] NUM_STATES    = 4'd12;

    // Byte groups
    localparam logic [3:0] GR_LETTER = 4'd0;
    localparam logic [3:0] GR_DIGIT  = 4'd1;
    localparam logic [3:0] GR_SYM    = 4'd2;
    localparam logic [3:0] GR_SPACE  = 4'd3;
    localparam logic [3:0] GR_APOS   = 4'd4;
    localparam logic [3:0] GR_QUOTE  = 4'd5;
    localparam logic [3:0] GR_SLASH  = 4'd6;
    localparam logic [3:0] GR_STAR   = 4'd7;
    localparam logic [3:0] GR_BSLASH = 4'd8;
    localparam logic [3:0] GR_EOL    = 4'd9;
    localparam logic [3:0] GR_OTHER  = 4'd10;
    localparam logic [3:0] GR_EOF    = 4'd11;

    // Actions; zero marks an undefined entry
    localparam logic [3:0] AC_NONE       = 4'd0;
    localparam logic [3:0] AC_NOOP       = 4'd1;
    localparam logic [3:0] AC_STORE      = 4'd2;
    localparam logic [3:0] AC_EMIT       = 4'd3;
    localparam logic [3:0] AC_EMIT_STORE = 4'd4;
    localparam logic [3:0] AC_STORE_EMIT = 4'd5;
    localparam logic [3:0] AC_CLEAR      = 4'd6;

    // Kinds of output byte carried from front to back
    localparam logic [1:0] KIND_SLASH = 2'd0;
    localparam logic [1:0] KIND_NL    = 2'd1;
    localparam logic [1:0] KIND_CHAR  = 2'd2;

    localparam logic [7:0] CHR_SLASH = 8'h2F;
    localparam logic [7:0] CHR_NL    = 8'h0A;

    localparam int QUEUE_DEPTH = 2;

    // One queued item: up to three output bytes
    typedef struct packed {
        logic [7:0]      char_byte;
        logic            eoi;
        logic [1:0]      count;
        logic [2:0][1:0] kind;
    } cmd_t;

    // Entry encodings: upper nibble next state plus one, lower nibble action
    function automatic logic [7:0] tr(input logic [3:0] n, input logic [3:0] a);
        tr = {n + 4'd1, a};
    endfunction

    function automatic logic [7:0] nx(input logic [3:0] n);
        nx = {n + 4'd1, AC_NONE};
    endfunction

    function automatic logic [7:0] ao(input logic [3:0] a);
        ao = {4'd0, a};
    endfunction

    // Sort a byte into its group
    function automatic logic [3:0] classify(input logic [7:0] c);
        logic [3:0] g;
        g = GR_OTHER;
        case (c)
            8'h0A, 8'h0D: g = GR_EOL;
            8'h5C:        g = GR_BSLASH;
            8'h2A:        g = GR_STAR;
            8'h2F:        g = GR_SLASH;
            8'h27:        g = GR_APOS;
            8'h22:        g = GR_QUOTE;
            8'h20, 8'h09: g = GR_SPACE;
            8'h5F:        g = GR_LETTER;
            8'h3A, 8'h2E, 8'h2B, 8'h2D, 8'h3D, 8'h3B, 8'h2C, 8'h5B, 8'h5D,
            8'h28, 8'h29, 8'h7B, 8'h7D, 8'h26, 8'h3C, 8'h3E, 8'h25, 8'h3F,
            8'h7E, 8'h23: g = GR_SYM;
            default:
            begin
                if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
                    g = GR_LETTER;
                else if (c >= 8'h30 && c <= 8'h39)
                    g = GR_DIGIT;
                else
                    g = GR_OTHER;
            end
        endcase
        classify = g;
    endfunction

    // Transition and action table; zero means undefined
    function automatic logic [7:0] trans_entry(input logic [3:0] st, input logic [3:0] gr);
        logic [7:0] e;
        e = 8'd0;
        case (st)
            ST_BASE:
            begin
                case (gr)
                    GR_LETTER: e = tr(ST_NAME, AC_STORE);
                    GR_DIGIT:  e = tr(ST_NUM, AC_STORE);
                    GR_SYM:    e = tr(ST_SYM, AC_STORE);
                    GR_SPACE:  e = nx(ST_BASE);
                    GR_APOS:   e = tr(ST_CHR, AC_STORE);
                    GR_QUOTE:  e = tr(ST_STR, AC_STORE);
                    GR_SLASH:  e = tr(ST_SLASH_SEEN, AC_STORE);
                    GR_STAR:   e = tr(ST_SYM, AC_STORE);
                    GR_BSLASH: e = tr(ST_SYM, AC_STORE);
                    GR_EOF:    e = ao(AC_EMIT);
                    default:   e = 8'd0;
                endcase
            end
            ST_CHR:
            begin
                case (gr)
                    GR_BSLASH: e = nx(ST_CHR_ESC);
                    GR_OTHER:  e = tr(ST_CHR_WAIT, AC_STORE);
                    GR_EOF:    e = ao(AC_EMIT);
                    default:   e = 8'd0;
                endcase
            end
            ST_CHR_ESC:
            begin
                case (gr)
                    GR_OTHER:  e = tr(ST_CHR_WAIT, AC_STORE);
                    GR_EOF:    e = ao(AC_EMIT);
                    default:   e = 8'd0;
                endcase
            end
            ST_CHR_WAIT:
            begin
                case (gr)
                    GR_APOS:   e = tr(ST_BASE, AC_STORE_EMIT);
                    GR_EOF:    e = ao(AC_EMIT);
                    default:   e = 8'd0;
                endcase
            end
            ST_SLASH_SEEN:
            begin
                case (gr)
                    GR_SLASH:  e = tr(ST_LINE_CMT, AC_CLEAR);
                    GR_STAR:   e = tr(ST_BLK_CMT, AC_CLEAR);
                    GR_DIGIT:  e = tr(ST_NUM, AC_EMIT_STORE);
                    GR_LETTER: e = tr(ST_NAME, AC_EMIT_STORE);
                    GR_OTHER:  e = tr(ST_BASE, AC_STORE_EMIT);
                    GR_EOF:    e = ao(AC_EMIT);
                    GR_SYM:    e = tr(ST_SYM, AC_STORE);
                    default:   e = 8'd0;
                endcase
            end
            ST_LINE_CMT:
            begin
                case (gr)
                    GR_OTHER:  e = nx(ST_LINE_CMT);
                    GR_EOL:    e = nx(ST_BASE);
                    GR_EOF:    e = ao(AC_EMIT);
                    default:   e = 8'd0;
                endcase
            end
            ST_BLK_CMT:
            begin
                case (gr)
                    GR_STAR:   e = nx(ST_BLK_END);
                    GR_OTHER:  e = nx(ST_BLK_CMT);
                    GR_EOF:    e = ao(AC_EMIT);
                    default:   e = 8'd0;
                endcase
            end
            ST_BLK_END:
            begin
                case (gr)
                    GR_SLASH:  e = nx(ST_BASE);
                    GR_OTHER:  e = nx(ST_BLK_CMT);
                    GR_EOF:    e = ao(AC_EMIT);
                    default:   e = 8'd0;
                endcase
            end
            ST_NUM:
            begin
                case (gr)
                    GR_DIGIT:  e = tr(ST_NUM, AC_STORE);
                    GR_SYM:    e = tr(ST_SYM, AC_EMIT_STORE);
                    GR_OTHER:  e = tr(ST_BASE, AC_EMIT);
                    GR_EOF:    e = ao(AC_EMIT);
                    default:   e = 8'd0;
                endcase
            end
            ST_SYM:
            begin
                case (gr)
                    GR_LETTER: e = tr(ST_NAME, AC_EMIT_STORE);
                    GR_DIGIT:  e = tr(ST_NUM, AC_EMIT_STORE);
                    GR_SYM:    e = tr(ST_SYM, AC_STORE);
                    GR_SPACE:  e = tr(ST_SYM, AC_NOOP);
                    GR_APOS:   e = tr(ST_CHR, AC_EMIT_STORE);
                    GR_QUOTE:  e = tr(ST_STR, AC_EMIT_STORE);
                    GR_OTHER:  e = tr(ST_BASE, AC_EMIT);
                    GR_SLASH:  e = tr(ST_SLASH_SEEN, AC_EMIT_STORE);
                    GR_EOL:    e = tr(ST_SYM, AC_NOOP);
                    GR_EOF:    e = ao(AC_EMIT);
                    default:   e = 8'd0;
                endcase
            end
            ST_NAME:
            begin
                case (gr)
                    GR_LETTER: e = tr(ST_NAME, AC_STORE);
                    GR_DIGIT:  e = tr(ST_NAME, AC_STORE);
                    GR_SYM:    e = tr(ST_SYM, AC_EMIT_STORE);
                    GR_STAR:   e = tr(ST_SYM, AC_EMIT_STORE);
                    GR_SPACE:  e = tr(ST_BASE, AC_EMIT);
                    GR_EOL:    e = tr(ST_BASE, AC_EMIT);
                    GR_EOF:    e = ao(AC_EMIT);
                    GR_SLASH:  e = tr(ST_SLASH_SEEN, AC_EMIT_STORE);
                    default:   e = 8'd0;
                endcase
            end
            ST_STR:
            begin
                case (gr)
                    GR_QUOTE:  e = tr(ST_BASE, AC_STORE_EMIT);
                    GR_OTHER:  e = tr(ST_STR, AC_STORE);
                    GR_EOF:    e = ao(AC_EMIT);
                    default:   e = 8'd0;
                endcase
            end
            default:   e = 8'd0;
        endcase
        trans_entry = e;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/cstm_front.sv -----
// Front end: accepts input bytes, runs the lexer table and queues output commands.
`default_nettype none

module cstm_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [7:0]    s_axis_tdata,   // [7:0] in_byte
    input  wire logic          s_axis_tuser,   // [0] end_of_input
    input  wire logic          q_full,
    output logic               q_push,
    output cstm_pkg::cmd_t     q_data
);
    import cstm_pkg::*;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [3:0] st_cur;
    logic [3:0] grp;
    logic [7:0] ent;
    logic [7:0] oth;
    logic [3:0] act;
    logic [3:0] nxf;
    logic [3:0] nxt;
    logic       held;
    logic       hold_new;
    logic       accept;
    logic [1:0] cnt;
    logic [2:0][1:0] kinds;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Look up the table and build the list of output bytes
    always_comb
    begin
        st_cur = (state_reg >= NUM_STATES) ? ST_BASE : state_reg;
        grp    = s_axis_tuser ? GR_EOF : classify(s_axis_tdata);
        ent    = trans_entry(st_cur, grp);
        oth    = trans_entry(st_cur, GR_OTHER);
        act    = (ent[3:0] != AC_NONE) ? ent[3:0] : oth[3:0];
        nxf    = (ent[7:4] != 4'd0) ? ent[7:4] : oth[7:4];
        nxt    = (nxf != 4'd0) ? (nxf - 4'd1) : st_cur;
        if (s_axis_tuser)
            nxt = ST_BASE;
        held     = (st_cur == ST_SLASH_SEEN);
        hold_new = (nxt == ST_SLASH_SEEN) && !held;

        cnt   = 2'd0;
        kinds = {3{KIND_NL}};
        case (act)
            AC_STORE:
            begin
                if (held)
                begin
                    kinds[cnt] = KIND_SLASH;
                    cnt        = cnt + 2'd1;
                end
                if (!hold_new)
                begin
                    kinds[cnt] = KIND_CHAR;
                    cnt        = cnt + 2'd1;
                end
            end
            AC_EMIT:
            begin
                if (held)
                begin
                    kinds[cnt] = KIND_SLASH;
                    cnt        = cnt + 2'd1;
                end
                kinds[cnt] = KIND_NL;
                cnt        = cnt + 2'd1;
            end
            AC_EMIT_STORE:
            begin
                if (held)
                begin
                    kinds[cnt] = KIND_SLASH;
                    cnt        = cnt + 2'd1;
                end
                kinds[cnt] = KIND_NL;
                cnt        = cnt + 2'd1;
                if (!hold_new)
                begin
                    kinds[cnt] = KIND_CHAR;
                    cnt        = cnt + 2'd1;
                end
            end
            AC_STORE_EMIT:
            begin
                if (held)
                begin
                    kinds[cnt] = KIND_SLASH;
                    cnt        = cnt + 2'd1;
                end
                kinds[cnt] = KIND_CHAR;
                cnt        = cnt + 2'd1;
                kinds[cnt] = KIND_NL;
                cnt        = cnt + 2'd1;
            end
            default:
            begin
                cnt = 2'd0;
            end
        endcase

        state_next = accept ? nxt : state_reg;
    end

    // Queue only items that give output
    assign q_push            = accept && (cnt != 2'd0);
    assign q_data.char_byte  = s_axis_tdata;
    assign q_data.eoi        = s_axis_tuser;
    assign q_data.count      = cnt;
    assign q_data.kind       = kinds;

    // Hold the lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_BASE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ----- rtl/cstm_queue.sv -----
// Short command queue between the front and back ends.
`default_nettype none

module cstm_queue
#(
    parameter int DEPTH = cstm_pkg::QUEUE_DEPTH
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire cstm_pkg::cmd_t push_data,
    input  wire logic           pop,
    output logic                full,
    output logic                not_empty,
    output cstm_pkg::cmd_t      rd_data
);
    import cstm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign rd_data   = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Advance the pointers and the fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ----- rtl/cstm_back.sv -----
// Back end: expands queued commands into output bytes, one transfer per cycle while the receiver is ready.
`default_nettype none

module cstm_back
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_not_empty,
    input  wire cstm_pkg::cmd_t q_data,
    output logic                q_pop,
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    output logic [7:0]          m_axis_tdata,   // [7:0] out_byte
    output logic                m_axis_tlast,   // last_of_run
    output logic                m_axis_tuser    // [0] file_done
);
    import cstm_pkg::*;

    cmd_t       cmd_reg;
    cmd_t       cmd_next;
    logic       cmd_valid_reg;
    logic       cmd_valid_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic [7:0] out_byte_next;
    logic       out_last_reg;
    logic       out_last_next;
    logic       out_done_reg;
    logic       out_done_next;
    logic       advance;
    logic       last_byte;
    logic [1:0] cur_kind;

    assign advance   = cmd_valid_reg && (!out_valid_reg || m_axis_tready);
    assign last_byte = (idx_reg == (cmd_reg.count - 2'd1));
    assign q_pop     = q_not_empty && (!cmd_valid_reg || (advance && last_byte));
    assign cur_kind  = cmd_reg.kind[idx_reg];

    // Step through the current command and load the output register
    always_comb
    begin
        cmd_next       = cmd_reg;
        cmd_valid_next = cmd_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;

        if (advance)
        begin
            case (cur_kind)
                KIND_SLASH: out_byte_next = CHR_SLASH;
                KIND_CHAR:  out_byte_next = cmd_reg.char_byte;
                default:    out_byte_next = CHR_NL;
            endcase
            out_valid_next = 1'b1;
            out_last_next  = last_byte;
            out_done_next  = last_byte && cmd_reg.eoi;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (q_pop)
        begin
            cmd_next       = q_data;
            cmd_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
        else if (advance && last_byte)
        begin
            cmd_valid_next = 1'b0;
        end
        else if (advance)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_done_reg;

endmodule

`default_nettype wire

// ----- rtl/c_source_token_minifier.sv -----
// Top level of the C source token minifier.
//
// Input stream (s_axis_*): one source byte per transfer in tdata; tuser set
// marks the end-of-input item, whose tdata is ignored.
// Output stream (m_axis_*): the bytes of the minified file, one token per
// line; tlast flags the last byte caused by an input item and tuser the last
// byte caused by an end-of-input item. An input item gives 0 to 3 bytes.
// The first byte of an item passes the queue write at its transfer, then
// the command register, then the output register, before it is offered.
// Throughput: one input item per cycle while each gives at most one byte
// and the receiver is ready; the output register moves one byte per cycle
// while the receiver is ready, so an item with more than one byte holds
// the back end for longer and the queue then fills and drops s_axis_tready.
// Items that give no byte are taken without queueing.
// Reset puts the lexer in its base state and empties the queue and output.
// A receiver stall holds the output byte steady; the front end keeps taking
// items until the QUEUE_DEPTH-entry queue is full.
`default_nettype none

module c_source_token_minifier
#(
    parameter int QUEUE_DEPTH = cstm_pkg::QUEUE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tuser,   // [0] end_of_input
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tlast,   // last_of_run
    output logic            m_axis_tuser    // [0] file_done
);
    import cstm_pkg::*;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_not_empty;
    cmd_t q_wr_data;
    cmd_t q_rd_data;

    cstm_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_wr_data)
    );

    cstm_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wr_data),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .rd_data   (q_rd_data)
    );

    cstm_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_data        (q_rd_data),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ----- tb/tb_c_source_token_minifier.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the C source token minifier: directed table, then random C-like text.
module tb_c_source_token_minifier;
    import cstm_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int TAIL_CYCLES     = 8;
    localparam int RANDOM_ITEMS    = 450;
    localparam int QUIET_ITEMS     = 80;
    localparam int HOLD_AT         = 60;
    localparam int PAUSE_AT        = 225;

    // One table entry of the lexer: optional next state, action (AC_NONE if undefined)
    typedef struct packed {
        logic       has_next;
        logic [3:0] nxt_state;
        logic [3:0] act;
    } lex_move_t;

    // One byte of the minified file as it should leave the block
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       file_done;
    } file_byte_t;

    // One source item
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } src_item_t;

    // One directed row; typed rows carry their expected bytes
    typedef struct packed {
        src_item_t       item;
        logic            typed;
        logic [1:0]      typed_n;
        logic [2:0][7:0] typed_bytes;
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;  // [7:0] in_byte
    logic       s_axis_tuser = 1'b0;   // [0] end_of_input
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;          // [7:0] out_byte
    logic       m_axis_tlast;          // last_of_run
    logic       m_axis_tuser;          // [0] file_done

    lex_move_t  move_tab [0:11][0:11];
    logic [3:0] lex_state = ST_BASE;
    file_byte_t pending_bytes [$];
    src_item_t  text_q [$];
    dir_row_t   dir_rows [$];
    string      sym_set = ":.+-=;,[](){}&<>%?~#";
    int         mismatches = 0;
    int         idle_cycles = 0;
    logic       hold_off_go = 1'b0;
    logic       hold_off_done = 1'b0;
    logic       quiet = 1'b0;

    always #5 clk = ~clk;

    c_source_token_minifier i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    function automatic lex_move_t mv(input logic has, input logic [3:0] n, input logic [3:0] a);
        lex_move_t m;
        m.has_next  = has;
        m.nxt_state = n;
        m.act       = a;
        return m;
    endfunction

    // Fill the lexer table; entries left at zero are undefined
    initial
    begin
        foreach (move_tab[s, g])
            move_tab[s][g] = '0;
        move_tab[ST_BASE][GR_LETTER]       = mv(1'b1, ST_NAME, AC_STORE);
        move_tab[ST_BASE][GR_DIGIT]        = mv(1'b1, ST_NUM, AC_STORE);
        move_tab[ST_BASE][GR_SYM]          = mv(1'b1, ST_SYM, AC_STORE);
        move_tab[ST_BASE][GR_SPACE]        = mv(1'b1, ST_BASE, AC_NONE);
        move_tab[ST_BASE][GR_APOS]         = mv(1'b1, ST_CHR, AC_STORE);
        move_tab[ST_BASE][GR_QUOTE]        = mv(1'b1, ST_STR, AC_STORE);
        move_tab[ST_BASE][GR_SLASH]        = mv(1'b1, ST_SLASH_SEEN, AC_STORE);
        move_tab[ST_BASE][GR_STAR]         = mv(1'b1, ST_SYM, AC_STORE);
        move_tab[ST_BASE][GR_BSLASH]       = mv(1'b1, ST_SYM, AC_STORE);
        move_tab[ST_CHR][GR_BSLASH]        = mv(1'b1, ST_CHR_ESC, AC_NONE);
        move_tab[ST_CHR][GR_OTHER]         = mv(1'b1, ST_CHR_WAIT, AC_STORE);
        move_tab[ST_CHR_ESC][GR_OTHER]     = mv(1'b1, ST_CHR_WAIT, AC_STORE);
        move_tab[ST_CHR_WAIT][GR_APOS]     = mv(1'b1, ST_BASE, AC_STORE_EMIT);
        move_tab[ST_SLASH_SEEN][GR_SLASH]  = mv(1'b1, ST_LINE_CMT, AC_CLEAR);
        move_tab[ST_SLASH_SEEN][GR_STAR]   = mv(1'b1, ST_BLK_CMT, AC_CLEAR);
        move_tab[ST_SLASH_SEEN][GR_DIGIT]  = mv(1'b1, ST_NUM, AC_EMIT_STORE);
        move_tab[ST_SLASH_SEEN][GR_LETTER] = mv(1'b1, ST_NAME, AC_EMIT_STORE);
        move_tab[ST_SLASH_SEEN][GR_OTHER]  = mv(1'b1, ST_BASE, AC_STORE_EMIT);
        move_tab[ST_SLASH_SEEN][GR_SYM]    = mv(1'b1, ST_SYM, AC_STORE);
        move_tab[ST_LINE_CMT][GR_OTHER]    = mv(1'b1, ST_LINE_CMT, AC_NONE);
        move_tab[ST_LINE_CMT][GR_EOL]      = mv(1'b1, ST_BASE, AC_NONE);
        move_tab[ST_BLK_CMT][GR_STAR]      = mv(1'b1, ST_BLK_END, AC_NONE);
        move_tab[ST_BLK_CMT][GR_OTHER]     = mv(1'b1, ST_BLK_CMT, AC_NONE);
        move_tab[ST_BLK_END][GR_SLASH]     = mv(1'b1, ST_BASE, AC_NONE);
        move_tab[ST_BLK_END][GR_OTHER]     = mv(1'b1, ST_BLK_CMT, AC_NONE);
        move_tab[ST_NUM][GR_DIGIT]         = mv(1'b1, ST_NUM, AC_STORE);
        move_tab[ST_NUM][GR_SYM]           = mv(1'b1, ST_SYM, AC_EMIT_STORE);
        move_tab[ST_NUM][GR_OTHER]         = mv(1'b1, ST_BASE, AC_EMIT);
        move_tab[ST_SYM][GR_LETTER]        = mv(1'b1, ST_NAME, AC_EMIT_STORE);
        move_tab[ST_SYM][GR_DIGIT]         = mv(1'b1, ST_NUM, AC_EMIT_STORE);
        move_tab[ST_SYM][GR_SYM]           = mv(1'b1, ST_SYM, AC_STORE);
        move_tab[ST_SYM][GR_SPACE]         = mv(1'b1, ST_SYM, AC_NOOP);
        move_tab[ST_SYM][GR_APOS]          = mv(1'b1, ST_CHR, AC_EMIT_STORE);
        move_tab[ST_SYM][GR_QUOTE]         = mv(1'b1, ST_STR, AC_EMIT_STORE);
        move_tab[ST_SYM][GR_OTHER]         = mv(1'b1, ST_BASE, AC_EMIT);
        move_tab[ST_SYM][GR_SLASH]         = mv(1'b1, ST_SLASH_SEEN, AC_EMIT_STORE);
        move_tab[ST_SYM][GR_EOL]           = mv(1'b1, ST_SYM, AC_NOOP);
        move_tab[ST_NAME][GR_LETTER]       = mv(1'b1, ST_NAME, AC_STORE);
        move_tab[ST_NAME][GR_DIGIT]        = mv(1'b1, ST_NAME, AC_STORE);
        move_tab[ST_NAME][GR_SYM]          = mv(1'b1, ST_SYM, AC_EMIT_STORE);
        move_tab[ST_NAME][GR_STAR]         = mv(1'b1, ST_SYM, AC_EMIT_STORE);
        move_tab[ST_NAME][GR_SPACE]        = mv(1'b1, ST_BASE, AC_EMIT);
        move_tab[ST_NAME][GR_EOL]          = mv(1'b1, ST_BASE, AC_EMIT);
        move_tab[ST_NAME][GR_SLASH]        = mv(1'b1, ST_SLASH_SEEN, AC_EMIT_STORE);
        move_tab[ST_STR][GR_QUOTE]         = mv(1'b1, ST_BASE, AC_STORE_EMIT);
        move_tab[ST_STR][GR_OTHER]         = mv(1'b1, ST_STR, AC_STORE);
        // every state ends the token at end of input
        for (int s = 0; s < 12; s++)
            move_tab[s][GR_EOF] = mv(1'b0, ST_BASE, AC_EMIT);
    end

    // Sort a source byte into its lexer group
    function automatic logic [3:0] byte_group(input logic [7:0] c);
        logic [3:0] g;
        g = GR_OTHER;
        if (c == 8'h0A || c == 8'h0D)
            g = GR_EOL;
        else if (c == "\\")
            g = GR_BSLASH;
        else if (c == "*")
            g = GR_STAR;
        else if (c == "/")
            g = GR_SLASH;
        else if (c == "'")
            g = GR_APOS;
        else if (c == "\"")
            g = GR_QUOTE;
        else if (c == " " || c == 8'h09)
            g = GR_SPACE;
        else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_")
            g = GR_LETTER;
        else if (c >= "0" && c <= "9")
            g = GR_DIGIT;
        else
        begin
            for (int i = 0; i < sym_set.len(); i++)
                if (sym_set[i] == c)
                    g = GR_SYM;
        end
        return g;
    endfunction

    // Advance the lexer by one item and work out the bytes it writes
    task automatic lex_step(input logic [7:0] c, input logic eoi,
                            output int n, output logic [2:0][7:0] ob);
        lex_move_t  e;
        lex_move_t  o;
        logic [3:0] st;
        logic [3:0] nxt;
        logic [3:0] act;
        logic       held;
        logic       hold_new;
        logic       put_slash;
        logic       nl_first;
        logic       put_char;
        logic       nl_after;
        st  = (lex_state >= NUM_STATES) ? ST_BASE : lex_state;
        e   = move_tab[st][eoi ? GR_EOF : byte_group(c)];
        o   = move_tab[st][GR_OTHER];
        act = (e.act != AC_NONE) ? e.act : o.act;
        nxt = e.has_next ? e.nxt_state : (o.has_next ? o.nxt_state : st);
        if (eoi)
            nxt = ST_BASE;
        held     = (st == ST_SLASH_SEEN);
        hold_new = (nxt == ST_SLASH_SEEN) && !held;
        // a held slash goes out ahead of anything but a comment opener
        put_slash = held && (act == AC_STORE || act == AC_EMIT ||
                             act == AC_EMIT_STORE || act == AC_STORE_EMIT);
        nl_first  = (act == AC_EMIT || act == AC_EMIT_STORE);
        put_char  = ((act == AC_STORE || act == AC_EMIT_STORE) && !hold_new) ||
                    act == AC_STORE_EMIT;
        nl_after  = (act == AC_STORE_EMIT);
        n  = 0;
        ob = '0;
        if (put_slash)
        begin
            ob[n] = CHR_SLASH;
            n++;
        end
        if (nl_first)
        begin
            ob[n] = CHR_NL;
            n++;
        end
        if (put_char)
        begin
            ob[n] = c;
            n++;
        end
        if (nl_after)
        begin
            ob[n] = CHR_NL;
            n++;
        end
        lex_state = nxt;
    endtask

    // Queue the bytes an item writes; the last one carries the flags
    task automatic queue_bytes(input int n, input logic [2:0][7:0] ob, input logic eoi);
        file_byte_t fb;
        for (int k = 0; k < n; k++)
        begin
            fb.out_byte    = ob[k];
            fb.last_of_run = (k == n - 1);
            fb.file_done   = eoi && (k == n - 1);
            pending_bytes.push_back(fb);
        end
    endtask

    task automatic add_row(input logic [7:0] b, input logic eoi);
        dir_row_t r;
        r = '0;
        r.item.in_byte      = b;
        r.item.end_of_input = eoi;
        dir_rows.push_back(r);
    endtask

    task automatic add_known(input logic [7:0] b, input logic eoi, input logic [1:0] n,
                             input logic [7:0] t0, input logic [7:0] t1);
        dir_row_t r;
        r = '0;
        r.item.in_byte      = b;
        r.item.end_of_input = eoi;
        r.typed             = 1'b1;
        r.typed_n           = n;
        r.typed_bytes       = {8'h00, t1, t0};
        dir_rows.push_back(r);
    endtask

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return 8'(8'h41 + r);
        else if (r < 52)
            return 8'(8'h61 + r - 26);
        return "_";
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'(8'h30 + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_printable(input logic [7:0] except);
        logic [7:0] b;
        b = 8'($urandom_range(32, 126));
        while (b == except)
            b = 8'($urandom_range(32, 126));
        return b;
    endfunction

    task automatic add_char(input logic [7:0] b);
        src_item_t it;
        it.in_byte      = b;
        it.end_of_input = 1'b0;
        text_q.push_back(it);
    endtask

    // Build random C-like text: mostly well-formed tokens, some noise
    task automatic gen_text();
        int         kind;
        src_item_t  it;
        logic [7:0] ws [4];
        ws[0] = " ";
        ws[1] = 8'h09;
        ws[2] = 8'h0A;
        ws[3] = 8'h0D;
        while (text_q.size() < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 19);
            case (kind)
                0, 1, 2, 3:
                begin
                    add_char(rand_letter());
                    repeat ($urandom_range(0, 5))
                        add_char(($urandom_range(0, 2) == 0) ? rand_digit() : rand_letter());
                end
                4, 5:
                begin
                    repeat ($urandom_range(1, 4))
                        add_char(rand_digit());
                end
                6, 7, 8:
                begin
                    repeat ($urandom_range(1, 3))
                    begin
                        case ($urandom_range(0, 7))
                            0:       add_char("*");
                            1:       add_char("\\");
                            default: add_char(sym_set[$urandom_range(0, sym_set.len() - 1)]);
                        endcase
                    end
                end
                9:
                begin
                    add_char("\"");
                    repeat ($urandom_range(0, 5))
                        add_char(rand_printable("\""));
                    add_char("\"");
                end
                10:
                begin
                    add_char("'");
                    if ($urandom_range(0, 1))
                        add_char("\\");
                    add_char(rand_printable("\\"));
                    add_char("'");
                end
                11:
                begin
                    add_char("/");
                    add_char("/");
                    repeat ($urandom_range(0, 6))
                        add_char(rand_printable(8'h0A));
                    add_char(ws[$urandom_range(2, 3)]);
                end
                12:
                begin
                    add_char("/");
                    add_char("*");
                    repeat ($urandom_range(0, 6))
                        add_char(($urandom_range(0, 3) == 0) ? "*" : rand_printable("/"));
                    add_char("*");
                    add_char("/");
                end
                13:
                begin
                    // lone slash followed by a printable byte other than a slash, which may still open a block comment
                    add_char("/");
                    add_char(rand_printable("/"));
                end
                14, 15:
                begin
                    add_char(8'($urandom_range(0, 255)));
                end
                16:
                begin
                    it.in_byte      = 8'($urandom_range(0, 255));
                    it.end_of_input = 1'b1;
                    text_q.push_back(it);
                end
                default:
                begin
                    repeat ($urandom_range(1, 2))
                        add_char(ws[$urandom_range(0, 3)]);
                end
            endcase
            if ($urandom_range(0, 1))
                add_char(ws[$urandom_range(0, 3)]);
        end
    endtask

    // Offer one item, wait for its transfer, then predict its bytes
    task automatic send_src(input src_item_t it, output int n, output logic [2:0][7:0] ob);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it.in_byte;
        s_axis_tuser  <= it.end_of_input;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        lex_step(it.in_byte, it.end_of_input, n, ob);
    endtask

    // Idle the sender for a short burst now and then
    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom_range(0, 255));
            repeat ($urandom_range(1, 3))
                @(posedge clk);
        end
    endtask

    // Stop offering until every expected byte has come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);
    endtask

    // Reset
    initial
    begin
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
    end

    // Sender
    initial
    begin
        int              n;
        logic [2:0][7:0] ob;
        int              idx;
        // end of input straight after reset writes a lone newline
        add_known(8'h00, 1'b1, 2'd1, CHR_NL, 8'h00);
        // top and bottom byte in the base state fall into other and are dropped
        add_known(8'hFF, 1'b0, 2'd0, 8'h00, 8'h00);
        add_known(8'h00, 1'b0, 2'd0, 8'h00, 8'h00);
        // name ended by a slash, then a line comment
        add_row("a", 1'b0);
        add_row("/", 1'b0);
        add_row("/", 1'b0);
        add_row(8'h0A, 1'b0);
        // block comment
        add_row("/", 1'b0);
        add_row("*", 1'b0);
        add_row("*", 1'b0);
        add_row("/", 1'b0);
        // number ended by a dropped byte
        add_row("1", 1'b0);
        add_row(8'h80, 1'b0);
        // escaped char literal with a dropped byte before the close
        add_row("'", 1'b0);
        add_row("\\", 1'b0);
        add_row("n", 1'b0);
        add_row("q", 1'b0);
        add_row("'", 1'b0);
        // string holding a tab
        add_row("\"", 1'b0);
        add_row(8'h09, 1'b0);
        add_row("\"", 1'b0);
        // held slash released by a carriage return: three bytes
        add_row("/", 1'b0);
        add_row(8'h0D, 1'b0);
        // held slash flushed ahead of the end-of-input newline
        add_row("+", 1'b0);
        add_row("/", 1'b0);
        add_known(8'h5A, 1'b1, 2'd2, CHR_SLASH, CHR_NL);
        gen_text();

        wait (rst_n);
        @(posedge clk);

        // directed table
        foreach (dir_rows[r])
        begin
            send_src(dir_rows[r].item, n, ob);
            if (dir_rows[r].typed)
                queue_bytes(int'(dir_rows[r].typed_n), dir_rows[r].typed_bytes,
                            dir_rows[r].item.end_of_input);
            else
                queue_bytes(n, ob, dir_rows[r].item.end_of_input);
            sender_gap();
        end
        drain();

        // random text
        for (idx = 0; idx < text_q.size(); idx++)
        begin
            if (idx == HOLD_AT)
                hold_off_go = 1'b1;
            if (idx == PAUSE_AT)
                drain();
            if (idx == text_q.size() - QUIET_ITEMS)
                quiet = 1'b1;
            send_src(text_q[idx], n, ob);
            queue_bytes(n, ob, text_q[idx].end_of_input);
            sender_gap();
        end
        drain();

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Receiver: short random stalls, one long hold-off
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_go && !hold_off_done)
            begin
                hold_off_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES)
                    @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3))
                    @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Check each output transfer against the oldest expected byte
    always @(posedge clk)
    begin : check_out
        file_byte_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_bytes.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected byte, expected none, actual %02h last %b done %b",
                         $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (m_axis_tdata !== want.out_byte)
                begin
                    mismatches++;
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, want.out_byte, m_axis_tdata);
                end
                if (m_axis_tlast !== want.last_of_run)
                begin
                    mismatches++;
                    $display("%0t: last_of_run expected %b actual %b",
                             $time, want.last_of_run, m_axis_tlast);
                end
                if (m_axis_tuser !== want.file_done)
                begin
                    mismatches++;
                    $display("%0t: file_done expected %b actual %b",
                             $time, want.file_done, m_axis_tuser);
                end
            end
        end
    end

    // Watchdog: end the run if no transfer happens for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule
